// ----- design/lla_pkg.sv -----
// shared types, codes and reset constants for the life-like automaton block
`default_nettype none

package lla_pkg;

    // default grid geometry
    localparam int ROWS_DEF = 64;
    localparam int COLS_DEF = 64;

    // port widths fixed by the request format
    localparam int MODE_W     = 2;
    localparam int IDX_W      = 6;
    localparam int CELLS_W    = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    // request modes
    localparam logic [MODE_W-1:0] MODE_WRITE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ADVANCE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BIRTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SURVIVE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS    = 3'd4;

    // configuration reset values
    localparam logic [8:0] BIRTH_RST   = 9'd8;
    localparam logic [8:0] SURVIVE_RST = 9'd12;
    localparam logic       WRAP_RST    = 1'b0;
    localparam logic [6:0] ROWS_RST    = 7'd64;
    localparam logic [6:0] COLS_RST    = 7'd64;

    // datapath operations issued by the controller
    typedef enum logic [2:0] {
        OP_NONE,
        OP_CLEAR,
        OP_WRITE,
        OP_READ,
        OP_RD_LAST,
        OP_RD_FIRST,
        OP_LOAD_FIRST,
        OP_ROW
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   accept;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic row_last;
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- design/lla_ram.sv -----
// generic single-write, single-read ram with registered read data
`default_nettype none

module lla_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- design/lla_ctrl.sv -----
// request sequencer: reset clearing pass, row access and generation sweep
`default_nettype none

module lla_ctrl import lla_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [MODE_W-1:0] i_mode,
    input  wire t_dp_stat          i_stat,
    output t_dp_cmd                o_cmd,
    output logic                   o_busy,
    output logic                   o_valid
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ADV_FIRST,
        S_ADV_LOAD,
        S_ADV_ROW
    } t_state;

    t_state r_state, n_state;
    logic   n_busy, n_valid;

    always_comb begin
        n_state      = r_state;
        n_valid      = 1'b0;
        o_cmd.op     = OP_NONE;
        o_cmd.accept = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.op = OP_CLEAR;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    n_valid      = 1'b1;
                    priority if (i_mode == MODE_WRITE) begin
                        o_cmd.op = OP_WRITE;
                    end else if (i_mode == MODE_READ) begin
                        o_cmd.op = OP_READ;
                    end else if (i_mode == MODE_ADVANCE) begin
                        o_cmd.op = OP_RD_LAST;
                        n_valid  = 1'b0;
                        n_state  = S_ADV_FIRST;
                    end else begin
                        o_cmd.op = OP_NONE;
                    end
                end
            end
            S_ADV_FIRST: begin
                o_cmd.op = OP_RD_FIRST;
                n_state  = S_ADV_LOAD;
            end
            S_ADV_LOAD: begin
                o_cmd.op = OP_LOAD_FIRST;
                n_state  = S_ADV_ROW;
            end
            S_ADV_ROW: begin
                o_cmd.op = OP_ROW;
                if (i_stat.row_last) begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_busy = (n_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            o_busy  <= 1'b1;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            o_busy  <= n_busy;
            o_valid <= n_valid;
        end
    end

endmodule

`default_nettype wire

// ----- design/lla_dp.sv -----
// datapath: configuration, grid memory, row window and next-generation logic
`default_nettype none

module lla_dp import lla_pkg::*; #(
    parameter int MAX_ROWS    = ROWS_DEF,
    parameter int MAX_COLUMNS = COLS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_stat                   o_stat,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [MODE_W-1:0]     i_mode,
    input  wire logic [IDX_W-1:0]      i_row_index,
    input  wire logic [CELLS_W-1:0]    i_row_cells,
    output logic      [CELLS_W-1:0]    o_row_value,
    output logic      [MODE_W-1:0]     o_answered_mode
);

    localparam int AW  = $clog2(MAX_ROWS);
    localparam int RW  = $clog2(MAX_ROWS + 1);
    localparam int CW  = MAX_COLUMNS;
    localparam int CXW = $clog2(MAX_COLUMNS);
    localparam int CNW = $clog2(MAX_COLUMNS + 1);

    // configuration
    logic [8:0] r_birth, r_survive;
    logic       r_wrap;
    logic [6:0] r_rows, r_cols;

    // sweep state
    logic [AW-1:0] r_cnt;
    logic [CW-1:0] r_above, r_cur, r_first;
    logic          r_rd_sel;
    logic [MODE_W-1:0] r_ans_mode;

    logic [RW-1:0]  rows_eff;
    logic [AW-1:0]  last_row;
    logic [CNW-1:0] cols_eff;
    logic [CXW-1:0] last_col;
    logic [AW:0]    cnt_plus2;
    logic           idx_ok;

    logic [CW-1:0] col_m, cur_m, below_m, next_row;
    logic [CW-1:0] wa, ea, wc, ec, wb, eb;
    logic [3:0]    nb_cnt [CW];

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [CW-1:0] ram_wdata, ram_rdata;

    // neighbor row seen one column to the west / east, border per wrap mode
    function automatic logic [CW-1:0] west_of(input logic [CW-1:0] r,
                                              input logic [CXW-1:0] lc,
                                              input logic w);
        return {r[CW-2:0], w & r[lc]};
    endfunction

    function automatic logic [CW-1:0] east_of(input logic [CW-1:0] r,
                                              input logic [CXW-1:0] lc,
                                              input logic w);
        logic [CW-1:0] v;
        v     = {1'b0, r[CW-1:1]};
        v[lc] = w & r[0];
        return v;
    endfunction

    // clamp the in-use geometry to the grid
    always_comb begin
        if (r_rows == 7'd0) begin
            rows_eff = RW'(1);
        end else if (32'(r_rows) > MAX_ROWS) begin
            rows_eff = RW'(MAX_ROWS);
        end else begin
            rows_eff = RW'(r_rows);
        end
        if (r_cols == 7'd0) begin
            cols_eff = CNW'(1);
        end else if (32'(r_cols) > MAX_COLUMNS) begin
            cols_eff = CNW'(MAX_COLUMNS);
        end else begin
            cols_eff = CNW'(r_cols);
        end
    end

    assign last_row  = AW'(rows_eff - RW'(1));
    assign last_col  = CXW'(cols_eff - CNW'(1));
    assign cnt_plus2 = {1'b0, r_cnt} + (AW+1)'(2);
    assign idx_ok    = 32'(i_row_index) < MAX_ROWS;

    assign o_stat.clr_last = (r_cnt == AW'(MAX_ROWS - 1));
    assign o_stat.row_last = (r_cnt == last_row);

    // next generation of the current row
    always_comb begin
        for (int j = 0; j < CW; j++) begin
            col_m[j] = (CXW'(j) <= last_col);
        end
        cur_m = r_cur & col_m;
        if (o_stat.row_last) begin
            below_m = r_wrap ? r_first : '0;
        end else begin
            below_m = ram_rdata & col_m;
        end
        wa = west_of(r_above, last_col, r_wrap);
        ea = east_of(r_above, last_col, r_wrap);
        wc = west_of(cur_m, last_col, r_wrap);
        ec = east_of(cur_m, last_col, r_wrap);
        wb = west_of(below_m, last_col, r_wrap);
        eb = east_of(below_m, last_col, r_wrap);
        for (int j = 0; j < CW; j++) begin
            nb_cnt[j] = 4'(wa[j]) + 4'(r_above[j]) + 4'(ea[j]) + 4'(wc[j])
                      + 4'(ec[j]) + 4'(wb[j]) + 4'(below_m[j]) + 4'(eb[j]);
            if (col_m[j]) begin
                next_row[j] = cur_m[j] ? r_survive[nb_cnt[j]] : r_birth[nb_cnt[j]];
            end else begin
                next_row[j] = r_cur[j];
            end
        end
    end

    // memory port steering
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_cnt;
        ram_wdata = '0;
        ram_raddr = '0;
        unique case (i_cmd.op)
            OP_CLEAR: begin
                ram_we = 1'b1;
            end
            OP_WRITE: begin
                ram_we    = idx_ok;
                ram_waddr = AW'(i_row_index);
                ram_wdata = i_row_cells[CW-1:0];
            end
            OP_READ: begin
                ram_raddr = AW'(i_row_index);
            end
            OP_RD_LAST: begin
                ram_raddr = last_row;
            end
            OP_RD_FIRST: begin
                ram_raddr = '0;
            end
            OP_LOAD_FIRST: begin
                ram_raddr = AW'(1);
            end
            OP_ROW: begin
                ram_we    = 1'b1;
                ram_wdata = next_row;
                if (cnt_plus2 <= {1'b0, last_row}) begin
                    ram_raddr = cnt_plus2[AW-1:0];
                end
            end
            OP_NONE: begin
                ram_we = 1'b0;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    lla_ram #(
        .WIDTH(CW),
        .DEPTH(MAX_ROWS)
    ) u_grid (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // configuration registers and row counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_birth   <= BIRTH_RST;
            r_survive <= SURVIVE_RST;
            r_wrap    <= WRAP_RST;
            r_rows    <= ROWS_RST;
            r_cols    <= COLS_RST;
            r_cnt     <= '0;
            r_rd_sel  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_BIRTH:   r_birth   <= i_cfg_data;
                    CFG_SURVIVE: r_survive <= i_cfg_data;
                    CFG_WRAP:    r_wrap    <= i_cfg_data[0];
                    CFG_ROWS:    r_rows    <= i_cfg_data[6:0];
                    CFG_COLS:    r_cols    <= i_cfg_data[6:0];
                    default:     ;
                endcase
            end
            if (i_cmd.op == OP_CLEAR || i_cmd.op == OP_ROW) begin
                r_cnt <= r_cnt + AW'(1);
            end else if (i_cmd.op == OP_RD_LAST) begin
                r_cnt <= '0;
            end
            if (i_cmd.accept) begin
                r_rd_sel <= (i_cmd.op == OP_READ) && idx_ok;
            end
        end
    end

    // row window and answered request
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_ans_mode <= i_mode;
        end
        if (i_cmd.op == OP_RD_FIRST) begin
            r_above <= r_wrap ? (ram_rdata & col_m) : '0;
        end else if (i_cmd.op == OP_ROW) begin
            r_above <= cur_m;
        end
        if (i_cmd.op == OP_LOAD_FIRST) begin
            r_first <= ram_rdata & col_m;
        end
        if (i_cmd.op == OP_LOAD_FIRST || i_cmd.op == OP_ROW) begin
            r_cur <= ram_rdata;
        end
    end

    assign o_row_value     = r_rd_sel ? CELLS_W'(ram_rdata) : '0;
    assign o_answered_mode = r_ans_mode;

endmodule

`default_nettype wire

// ----- design/life_like_automaton_generation.sv -----
// top level of the life-like cellular automaton generation engine
//
//  channel   signals                                   direction  handshake
//  request   i_start, i_mode, i_row_index, i_row_cells  in         start & !busy
//  result    o_valid, o_row_value, o_answered_mode      out        one-cycle strobe
//  config    i_cfg_we, i_cfg_idx, i_cfg_data            in         write enable
//
//  write, read and unused-mode requests: result strobe in the cycle after the request
//  advance: one row per cycle (rows in use, clamped) through the single read port
//    of the grid memory, after the row window is primed by reads of the last, first and second rows
//  reset clears the grid in a pass over all MAX_ROWS rows with busy high
//  results cannot be held off; a new request is taken in the cycle a result shows
`default_nettype none

module life_like_automaton_generation import lla_pkg::*; #(
    parameter int MAX_ROWS    = ROWS_DEF,
    parameter int MAX_COLUMNS = COLS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // request
    input  wire logic                  i_start,
    input  wire logic [MODE_W-1:0]     i_mode,
    input  wire logic [IDX_W-1:0]      i_row_index,
    input  wire logic [CELLS_W-1:0]    i_row_cells,
    output logic                       o_busy,
    // result
    output logic                       o_valid,
    output logic      [CELLS_W-1:0]    o_row_value,
    output logic      [MODE_W-1:0]     o_answered_mode,
    // configuration
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequencer: owns busy and the result strobe
    lla_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_start),
        .i_mode (i_mode),
        .i_stat (dp_stat),
        .o_cmd  (dp_cmd),
        .o_busy (o_busy),
        .o_valid(o_valid)
    );

    // grid memory, rule registers and the three-row window
    lla_dp #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLUMNS(MAX_COLUMNS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_mode         (i_mode),
        .i_row_index    (i_row_index),
        .i_row_cells    (i_row_cells),
        .o_row_value    (o_row_value),
        .o_answered_mode(o_answered_mode)
    );

endmodule

`default_nettype wire

// ----- design/lla_checker.sv -----
// port-level checks for the automaton engine and their bind
`default_nettype none

module lla_checker import lla_pkg::*; (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_start,
    input wire logic [MODE_W-1:0]     i_mode,
    input wire logic                  o_busy,
    input wire logic                  o_valid,
    input wire logic [CELLS_W-1:0]    o_row_value,
    input wire logic [MODE_W-1:0]     o_answered_mode
);

    logic req_short, req_adv;

    assign req_short = i_start && !o_busy && (i_mode != MODE_ADVANCE);
    assign req_adv   = i_start && !o_busy && (i_mode == MODE_ADVANCE);

    // non-advance requests answer in the next cycle with their own mode
    a_short_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_short |=> o_valid && (o_answered_mode == $past(i_mode)))
        else $error("single-cycle request not answered next cycle");

    // an advance keeps the block busy and gives no immediate result
    a_adv_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_adv |=> o_busy && !o_valid)
        else $error("advance did not hold busy");

    // only reads carry row data
    a_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_answered_mode != MODE_READ)) |-> (o_row_value == '0))
        else $error("non-read result carries row data");

    // an advance result ends the busy period
    a_adv_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_answered_mode == MODE_ADVANCE)) |-> !o_busy && $past(o_busy))
        else $error("advance result out of place");

endmodule

bind life_like_automaton_generation lla_checker u_lla_checker (.*);

`default_nettype wire
